// ===== rtl/smooth_vertex_normal_engine_defines.svh =====
// ============================================================================
// Smooth vertex normal engine assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef SMOOTH_VERTEX_NORMAL_ENGINE_DEFINES_SVH
`define SMOOTH_VERTEX_NORMAL_ENGINE_DEFINES_SVH

// same-cycle implication
`define SVNE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SVNE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/svne_pkg.sv =====
// ============================================================================
// Smooth vertex normal engine package
// Item types, field widths, item kinds and default sizes.
// ============================================================================
package svne_pkg;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int NORM_W = 16;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_SUM_WIDTH    = 24;

    // unit length in Q1.14
    localparam int NORM_ONE = 16384;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        vertex_slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_in_item;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     zero_sum;
    } t_out_item;

endpackage

// ===== rtl/smooth_vertex_normal_engine.sv =====
// ============================================================================
// Smooth vertex normal engine
// Vertex store and per-vertex face normal accumulators with normalisation.
// ============================================================================
// Usage:
//  Input channel (i_in_valid / o_in_stall / i_in_item) takes one item at a
//  time and stalls until the sequencer is back in idle.
//  write_vertex: stored as the item is taken. add_triangle: position fetch,
//  cross product on one shared 32x32 multiplier, magnitude shifting,
//  squares, bit-pair square root, restoring division of each component
//  and accumulator read-modify-write; a degenerate face skips the
//  division. read_normal: the stored sum takes the same magnitude, square
//  root and division steps (a zero sum skips the division, a slot out of
//  range skips them all). clear sweeps the accumulator memory, one entry a
//  cycle. Rate is set by the square root loop and the divider.
//  Output channel (o_out_valid / i_out_stall / o_out_item) carries one
//  item per read_normal from an output register; the next item is taken
//  while a result waits, and a further result waits for it to drain.
//  After reset the accumulator memory is cleared by the same sweep before
//  any item is taken.
// ============================================================================
`include "smooth_vertex_normal_engine_defines.svh"

module smooth_vertex_normal_engine #(
    parameter int MAX_VERTICES = svne_pkg::DEF_MAX_VERTICES,
    parameter int SUM_WIDTH    = svne_pkg::DEF_SUM_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  svne_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output svne_pkg::t_out_item  o_out_item
);
    import svne_pkg::*;

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CW    = (AW > 6) ? AW : 6;
    localparam int SW3   = 3 * SUM_WIDTH;
    localparam int MAG_W = 36;
    localparam int V_W   = 37;
    localparam int PW3   = 3 * POS_W;

    localparam logic [3:0] ST_CLR   = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_POS   = 4'd2;
    localparam logic [3:0] ST_CROSS = 4'd3;
    localparam logic [3:0] ST_MAGS  = 4'd4;
    localparam logic [3:0] ST_NSH   = 4'd5;
    localparam logic [3:0] ST_SQ    = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_DIVI  = 4'd8;
    localparam logic [3:0] ST_DIV   = 4'd9;
    localparam logic [3:0] ST_DIVE  = 4'd10;
    localparam logic [3:0] ST_ACC   = 4'd11;
    localparam logic [3:0] ST_RRD   = 4'd12;
    localparam logic [3:0] ST_RLD   = 4'd13;
    localparam logic [3:0] ST_PUT   = 4'd14;

    function automatic logic in_rng(input logic [IDX_W-1:0] idx);
        return (32'(idx) < MAX_VERTICES);
    endfunction

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] e;
        e = 32'(idx);
        return e[AW-1:0];
    endfunction

    // memories
    logic [PW3-1:0] pos_mem [MAX_VERTICES];
    logic [SW3-1:0] sum_mem [MAX_VERTICES];

    // control
    logic [3:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_comp;
    logic          r_is_read;
    logic          r_out_valid;

    // payload
    logic [AW-1:0]           r_corner [3];
    logic [AW-1:0]           r_slot;
    logic signed [POS_W-1:0] r_pv [3][3];
    logic signed [V_W-1:0]   r_v [3];
    logic signed [63:0]      r_prod;
    logic [MAG_W-1:0]        r_mag [3];
    logic                    r_neg [3];
    logic [63:0]             r_s;
    logic [63:0]             r_root;
    logic [63:0]             r_bit;
    logic [45:0]             r_num;
    logic [32:0]             r_rem;
    logic [15:0]             r_quo;
    logic signed [15:0]      r_n [3];
    logic                    r_zero;
    t_out_item               r_out_item;
    logic [PW3-1:0]          r_pos_rd;
    logic [SW3-1:0]          r_sum_rd;

    logic in_acc;
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // edge vectors
    logic signed [POS_W:0] ab [3];
    logic signed [POS_W:0] ac [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ab[i] = (POS_W+1)'(r_pv[1][i]) - (POS_W+1)'(r_pv[0][i]);
            ac[i] = (POS_W+1)'(r_pv[2][i]) - (POS_W+1)'(r_pv[0][i]);
        end
    end

    // shared multiplier operand select
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [1:0]         sq_sel;
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        sq_sel = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
        if (r_state == ST_CROSS) begin
            case (r_cnt[2:0])
                3'd0: begin mul_a = 32'(ab[1]); mul_b = 32'(ac[2]); end
                3'd1: begin mul_a = 32'(ab[2]); mul_b = 32'(ac[1]); end
                3'd2: begin mul_a = 32'(ab[2]); mul_b = 32'(ac[0]); end
                3'd3: begin mul_a = 32'(ab[0]); mul_b = 32'(ac[2]); end
                3'd4: begin mul_a = 32'(ab[0]); mul_b = 32'(ac[1]); end
                3'd5: begin mul_a = 32'(ab[1]); mul_b = 32'(ac[0]); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else begin
            mul_a = $signed({2'b00, r_mag[sq_sel][29:0]});
            mul_b = mul_a;
        end
        mul_p = mul_a * mul_b;
    end

    // address selects
    logic [1:0]    pos_sel;
    logic [AW-1:0] pos_raddr;
    logic [AW-1:0] acc_addr;
    logic [AW-1:0] sum_raddr;
    logic [2:0]    cj;
    always_comb begin
        pos_sel   = (r_cnt[1:0] == 2'd3) ? 2'd2 : r_cnt[1:0];
        pos_raddr = r_corner[pos_sel];
        acc_addr  = r_corner[(r_cnt[2:1] == 2'd3) ? 2'd2 : r_cnt[2:1]];
        sum_raddr = (r_state == ST_ACC) ? acc_addr : r_slot;
        cj        = r_cnt[2:0] - 3'd1;
    end

    // saturating accumulate
    logic [SW3-1:0] sat_sum;
    always_comb begin
        logic signed [SUM_WIDTH-1:0] s;
        logic signed [SUM_WIDTH:0]   t;
        for (int i = 0; i < 3; i++) begin
            s = $signed(r_sum_rd[i*SUM_WIDTH +: SUM_WIDTH]);
            t = (SUM_WIDTH+1)'(s) + (SUM_WIDTH+1)'(r_n[i]);
            if (t[SUM_WIDTH] != t[SUM_WIDTH-1])
                sat_sum[i*SUM_WIDTH +: SUM_WIDTH] = t[SUM_WIDTH] ?
                    {1'b1, {(SUM_WIDTH-1){1'b0}}} : {1'b0, {(SUM_WIDTH-1){1'b1}}};
            else
                sat_sum[i*SUM_WIDTH +: SUM_WIDTH] = t[SUM_WIDTH-1:0];
        end
    end

    // square root and divider step logic
    logic [63:0] trial;
    logic [45:0] num_c;
    logic [33:0] dtry;
    logic [33:0] dden;
    logic        dge;
    logic [15:0] qcl;
    assign trial = r_root + r_bit;
    assign num_c = {1'b0, r_mag[r_comp == 2'd3 ? 2'd2 : r_comp][29:0], 15'b0}
                 + 46'(r_root[31:0]);
    assign dtry  = {r_rem, r_num[15]};
    assign dden  = {1'b0, r_root[31:0], 1'b0};
    assign dge   = (dtry >= dden);
    assign qcl   = (r_quo > 16'(NORM_ONE)) ? 16'(NORM_ONE) : r_quo;

    logic big;
    always_comb begin
        big = 1'b0;
        for (int i = 0; i < 3; i++)
            big = big | (|r_mag[i][MAG_W-1:30]);
    end

    // memory ports
    logic sum_we;
    assign sum_we = (r_state == ST_CLR) || ((r_state == ST_ACC) && r_cnt[0]);

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in_item.kind == KIND_WRITE) && in_rng(i_in_item.vertex_slot))
            pos_mem[to_addr(i_in_item.vertex_slot)] <=
                {i_in_item.pos_x, i_in_item.pos_y, i_in_item.pos_z};
        r_pos_rd <= pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we)
            sum_mem[(r_state == ST_CLR) ? r_cnt[AW-1:0] : acc_addr] <=
                (r_state == ST_CLR) ? '0 : sat_sum;
        r_sum_rd <= sum_mem[sum_raddr];
    end

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cnt       <= '0;
            r_comp      <= '0;
            r_is_read   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // output register drains independently
            if ((r_state == ST_PUT) && !(r_out_valid && i_out_stall)) begin
                r_out_valid <= 1'b1;
                r_out_item  <= '{norm_x: r_n[0], norm_y: r_n[1], norm_z: r_n[2],
                                 zero_sum: r_zero};
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLR: begin
                    if (r_cnt == CW'(MAX_VERTICES - 1)) begin
                        r_state <= ST_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (in_acc) begin
                        case (i_in_item.kind)
                            KIND_TRI: begin
                                r_is_read <= 1'b0;
                                r_corner[0] <= to_addr(i_in_item.corner_a);
                                r_corner[1] <= to_addr(i_in_item.corner_b);
                                r_corner[2] <= to_addr(i_in_item.corner_c);
                                if (in_rng(i_in_item.corner_a) && in_rng(i_in_item.corner_b)
                                    && in_rng(i_in_item.corner_c))
                                    r_state <= ST_POS;
                            end
                            KIND_CLEAR: r_state <= ST_CLR;
                            KIND_READ: begin
                                r_is_read <= 1'b1;
                                r_slot    <= to_addr(i_in_item.vertex_slot);
                                if (in_rng(i_in_item.vertex_slot)) begin
                                    r_state <= ST_RRD;
                                end else begin
                                    for (int i = 0; i < 3; i++) r_n[i] <= '0;
                                    r_zero  <= 1'b1;
                                    r_state <= ST_PUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                // fetch the three corner positions
                ST_POS: begin
                    if (r_cnt[1:0] != 2'd0) begin
                        r_pv[cj[1:0]][0] <= $signed(r_pos_rd[PW3-1 -: POS_W]);
                        r_pv[cj[1:0]][1] <= $signed(r_pos_rd[2*POS_W-1 -: POS_W]);
                        r_pv[cj[1:0]][2] <= $signed(r_pos_rd[POS_W-1:0]);
                    end
                    if (r_cnt[1:0] == 2'd3) begin
                        r_cnt   <= '0;
                        r_state <= ST_CROSS;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                // six products, each accumulated from r_prod in the cycle after it is formed
                ST_CROSS: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_prod <= mul_p;
                    if (r_cnt[2:0] == 3'd0) begin
                        for (int i = 0; i < 3; i++) r_v[i] <= '0;
                    end else if (cj[0] == 1'b0) begin
                        r_v[cj[2:1]] <= r_v[cj[2:1]] + V_W'(r_prod);
                    end else begin
                        r_v[cj[2:1]] <= r_v[cj[2:1]] - V_W'(r_prod);
                    end
                    if (r_cnt[2:0] == 3'd6) r_state <= ST_MAGS;
                end
                ST_MAGS: begin
                    for (int i = 0; i < 3; i++) begin
                        r_neg[i] <= (r_v[i] < 0);
                        r_mag[i] <= MAG_W'((r_v[i] < 0) ? -r_v[i] : r_v[i]);
                    end
                    r_state <= ST_NSH;
                end
                // bring every magnitude below 2^30
                ST_NSH: begin
                    r_cnt <= '0;
                    r_s   <= '0;
                    if (big) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_prod <= mul_p;
                    if (r_cnt[1:0] != 2'd0) r_s <= r_s + $unsigned(r_prod);
                    if (r_cnt[1:0] == 2'd3) begin
                        r_root  <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= ST_SQRT;
                    end
                end
                // one result bit per cycle
                ST_SQRT: begin
                    if (r_s >= trial) begin
                        r_s    <= r_s - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) r_state <= ST_DIVE;
                    r_comp <= 2'd3;
                end
                ST_DIVI: begin
                    r_num   <= num_c;
                    r_rem   <= 33'(num_c[45:16]);
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_rem <= dge ? 33'(dtry - dden) : dtry[32:0];
                    r_quo <= {r_quo[14:0], dge};
                    r_num <= r_num << 1;
                    if (r_cnt[3:0] == 4'd15) r_state <= ST_DIVE;
                end
                // comp 3 marks the entry straight from the square root
                ST_DIVE: begin
                    if (r_comp == 2'd3) begin
                        if (r_root == 64'd0) begin
                            for (int i = 0; i < 3; i++) r_n[i] <= '0;
                            r_zero  <= 1'b1;
                            r_cnt   <= '0;
                            r_state <= r_is_read ? ST_PUT : ST_ACC;
                        end else begin
                            r_zero  <= 1'b0;
                            r_comp  <= 2'd0;
                            r_state <= ST_DIVI;
                        end
                    end else begin
                        r_n[r_comp] <= r_neg[r_comp] ? -$signed(qcl) : $signed(qcl);
                        if (r_comp == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= r_is_read ? ST_PUT : ST_ACC;
                        end else begin
                            r_comp  <= r_comp + 1'b1;
                            r_state <= ST_DIVI;
                        end
                    end
                end
                // read then write each corner in turn
                ST_ACC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[2:0] == 3'd5) r_state <= ST_IDLE;
                end
                ST_RRD: r_state <= ST_RLD;
                ST_RLD: begin
                    for (int i = 0; i < 3; i++)
                        r_v[i] <= V_W'($signed(r_sum_rd[i*SUM_WIDTH +: SUM_WIDTH]));
                    r_state <= ST_MAGS;
                end
                ST_PUT: begin
                    if (!(r_out_valid && i_out_stall)) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    `SVNE_ASSERT(a_clr_stalls, r_state == ST_CLR, o_in_stall, "item taken during sweep")
    `SVNE_ASSERT(a_quo_bound, (r_state == ST_DIVE) && (r_comp != 2'd3), r_quo <= 16'(NORM_ONE), "quotient above unit")
    `SVNE_ASSERT_NEXT(a_put_valid, (r_state == ST_PUT) && !(r_out_valid && i_out_stall), o_out_valid, "result not presented")

endmodule
